[rtl/cst_pkg.sv]
// Shared types, character codes and the byte classification function of the tokenizer.
package cst_pkg;

   localparam int MAX_SET_CHARS = 8;
   localparam int SET_WIDTH     = 64;
   localparam int COUNT_WIDTH   = 4;
   localparam int MAX_RESULTS   = 4;
   localparam int RESULT_CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int RESULT_IDX_W  = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [1:0] CSR_SEP_CHARS = 2'd0;
   localparam logic [1:0] CSR_SEP_COUNT = 2'd1;
   localparam logic [1:0] CSR_DEL_CHARS = 2'd2;
   localparam logic [1:0] CSR_DEL_COUNT = 2'd3;

   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_SLASH  = 6'b000010,
      MODE_LINE   = 6'b000100,
      MODE_BLOCK  = 6'b001000,
      MODE_STAR   = 6'b010000,
      MODE_AFTER  = 6'b100000
   } scan_mode_type;

   // Outcome of classifying one byte: up to two token bytes and the new held byte.
   // The second token byte is always a one-byte delimiter token, so it always ends.
   typedef struct packed {
      logic       e0_valid;
      logic [7:0] e0_byte;
      logic       e0_end;
      logic       e1_valid;
      logic [7:0] e1_byte;
      logic       held_valid;
      logic [7:0] held_byte;
   } cls_type;

   // The token bytes caused by one input byte, in order.
   typedef struct packed {
      logic [RESULT_CNT_W-1:0]   count;
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [MAX_RESULTS-1:0]    ends;
   } bundle_type;

   function automatic cls_type classify_f(
      input logic       en,
      input logic       held_valid,
      input logic [7:0] held_byte,
      input logic [7:0] c,
      input logic       is_sep,
      input logic       is_delim
   );
      cls_type r;
      r.e0_valid   = 1'b0;
      r.e0_byte    = held_byte;
      r.e0_end     = 1'b1;
      r.e1_valid   = 1'b0;
      r.e1_byte    = c;
      r.held_valid = held_valid;
      r.held_byte  = held_byte;
      if (en) begin
         if (is_sep) begin
            r.e0_valid   = held_valid;
            r.held_valid = 1'b0;
         end else if (is_delim) begin
            r.e0_valid   = held_valid;
            r.e1_valid   = 1'b1;
            r.held_valid = 1'b0;
         end else begin
            r.e0_valid   = held_valid;
            r.e0_end     = 1'b0;
            r.held_valid = 1'b1;
            r.held_byte  = c;
         end
      end
      return r;
   endfunction

endpackage

[rtl/cst_front.sv]
// Front end: configuration registers, comment scanner and per-byte token byte bundles.
module cst_front import cst_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [SET_WIDTH-1:0]   csr_wdata,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  logic                   queue_full,
   output logic                   push_valid,
   output bundle_type             push_data
);

   logic [SET_WIDTH-1:0]   sep_chars_ff, sep_chars_in;
   logic [COUNT_WIDTH-1:0] sep_count_ff, sep_count_in;
   logic [SET_WIDTH-1:0]   del_chars_ff, del_chars_in;
   logic [COUNT_WIDTH-1:0] del_count_ff, del_count_in;

   scan_mode_type mode_ff, mode_in, mode_mid;
   logic          held_valid_ff, held_valid_in;
   logic [7:0]    held_byte_ff, held_byte_in;

   logic       accept;
   logic       sep_c, del_c, sep_s, del_s;
   logic       en1, en2, s1, d1;
   logic [7:0] b1;
   cls_type    r1, r2, r3, r4;

   logic [2*MAX_RESULTS-1:0]       slot_v;
   logic [2*MAX_RESULTS-1:0][7:0]  slot_b;
   logic [2*MAX_RESULTS-1:0]       slot_e;
   logic [RESULT_CNT_W-1:0]        n;

   function automatic logic in_set(
      input logic [SET_WIDTH-1:0]   chars,
      input logic [COUNT_WIDTH-1:0] cnt,
      input logic [7:0]             c
   );
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < MAX_SET_CHARS; k++) begin
         if ((COUNT_WIDTH'(k) < cnt) && (chars[8*k +: 8] == c)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      sep_chars_in = sep_chars_ff;
      sep_count_in = sep_count_ff;
      del_chars_in = del_chars_ff;
      del_count_in = del_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEP_CHARS: sep_chars_in = csr_wdata;
            CSR_SEP_COUNT: sep_count_in = csr_wdata[COUNT_WIDTH-1:0];
            CSR_DEL_CHARS: del_chars_in = csr_wdata;
            CSR_DEL_COUNT: del_count_in = csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // A byte found in both sets is treated as a separator.
      sep_c = in_set(sep_chars_ff, sep_count_ff, in_byte);
      del_c = in_set(del_chars_ff, del_count_ff, in_byte);
      sep_s = in_set(sep_chars_ff, sep_count_ff, CHAR_SLASH);
      del_s = in_set(del_chars_ff, del_count_ff, CHAR_SLASH);

      en1      = 1'b0;
      en2      = 1'b0;
      b1       = in_byte;
      s1       = sep_c;
      d1       = del_c;
      mode_mid = mode_ff;

      case (mode_ff)
         MODE_SLASH: begin
            if (in_byte == CHAR_SLASH) begin
               mode_mid = MODE_LINE;
            end else if (in_byte == CHAR_STAR) begin
               mode_mid = MODE_BLOCK;
            end else begin
               // The held slash was a plain byte after all.
               mode_mid = MODE_NORMAL;
               en1      = 1'b1;
               b1       = CHAR_SLASH;
               s1       = sep_s;
               d1       = del_s;
               en2      = 1'b1;
            end
         end
         MODE_LINE: begin
            if (in_byte == CHAR_NEWLINE) begin
               mode_mid = MODE_NORMAL;
               en1      = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (in_byte == CHAR_STAR) begin
               mode_mid = MODE_STAR;
            end
         end
         MODE_STAR: begin
            if (in_byte == CHAR_SLASH) begin
               mode_mid = MODE_AFTER;
            end else if (in_byte != CHAR_STAR) begin
               mode_mid = MODE_BLOCK;
            end
         end
         MODE_AFTER: begin
            mode_mid = MODE_NORMAL;
            en1      = 1'b1;
            // A delimiter that ends a pending token is looked at again with
            // comment detection, so a slash here can still open a comment.
            if (!sep_c && del_c && held_valid_ff) begin
               s1 = 1'b1;
               d1 = 1'b0;
               if (in_byte == CHAR_SLASH) begin
                  mode_mid = MODE_SLASH;
               end else begin
                  en2 = 1'b1;
               end
            end
         end
         default: begin
            if (in_byte == CHAR_SLASH) begin
               mode_mid = MODE_SLASH;
            end else begin
               mode_mid = MODE_NORMAL;
               en1      = 1'b1;
            end
         end
      endcase

      r1 = classify_f(en1, held_valid_ff, held_byte_ff, b1, s1, d1);
      r2 = classify_f(en2, r1.held_valid, r1.held_byte, in_byte, sep_c, del_c);
      // At the end of the stream a held slash is plain, then the pending token is flushed.
      r3 = classify_f(in_last && (mode_mid == MODE_SLASH), r2.held_valid, r2.held_byte,
                      CHAR_SLASH, sep_s, del_s);
      r4 = classify_f(in_last, r3.held_valid, r3.held_byte, in_byte, 1'b1, 1'b0);

      mode_in       = in_last ? MODE_NORMAL : mode_mid;
      held_valid_in = r4.held_valid;
      held_byte_in  = in_last ? 8'h00 : r4.held_byte;

      slot_v = {r4.e1_valid, r4.e0_valid, r3.e1_valid, r3.e0_valid,
                r2.e1_valid, r2.e0_valid, r1.e1_valid, r1.e0_valid};
      slot_b = {r4.e1_byte, r4.e0_byte, r3.e1_byte, r3.e0_byte,
                r2.e1_byte, r2.e0_byte, r1.e1_byte, r1.e0_byte};
      slot_e = {1'b1, r4.e0_end, 1'b1, r3.e0_end,
                1'b1, r2.e0_end, 1'b1, r1.e0_end};

      push_data = '0;
      n         = '0;
      for (int i = 0; i < 2*MAX_RESULTS; i++) begin
         if (slot_v[i] && (n < RESULT_CNT_W'(MAX_RESULTS))) begin
            push_data.bytes[n[RESULT_IDX_W-1:0]] = slot_b[i];
            push_data.ends[n[RESULT_IDX_W-1:0]]  = slot_e[i];
            n = n + RESULT_CNT_W'(1);
         end
      end
      push_data.count = n;
      push_valid      = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_chars_ff  <= '0;
         sep_count_ff  <= '0;
         del_chars_ff  <= '0;
         del_count_ff  <= '0;
         mode_ff       <= MODE_NORMAL;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= 8'h00;
      end else begin
         sep_chars_ff <= sep_chars_in;
         sep_count_ff <= sep_count_in;
         del_chars_ff <= del_chars_in;
         del_count_ff <= del_count_in;
         if (accept) begin
            mode_ff       <= mode_in;
            held_valid_ff <= held_valid_in;
            held_byte_ff  <= held_byte_in;
         end
      end
   end

endmodule

[rtl/cst_queue.sv]
// Small register queue of token byte bundles between the front and back ends.
module cst_queue import cst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output bundle_type head
);

   bundle_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/cst_back.sv]
// Back end: unpacks each bundle into single token bytes behind an output register.
module cst_back import cst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  bundle_type head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   logic [RESULT_IDX_W-1:0] idx_ff, idx_in;
   logic                    valid_ff, valid_in;
   logic [7:0]              byte_ff;
   logic                    end_ff;
   logic                    run_last_ff;
   logic                    load, item_last;

   assign load      = !empty && (!valid_ff || rsp_tready);
   assign item_last = ({1'b0, idx_ff} + RESULT_CNT_W'(1)) == head.count;
   assign pop       = load && item_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = item_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= head.bytes[idx_ff];
         end_ff      <= head.ends[idx_ff];
         run_last_ff <= item_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = end_ff;
   assign rsp_tuser  = run_last_ff;

endmodule

[rtl/comment_skipping_tokenizer_unit.sv]
// Top level of the comment-skipping byte tokenizer.
//
//  channel  direction  handshake               payload
//  req      in         req_tvalid/req_tready   tdata text_byte, tlast stream_last
//  rsp      out        rsp_tvalid/rsp_tready   tdata token_byte, tlast token_end,
//                                              tuser run_last
//  csr      in         csr_we                  csr_index, csr_wdata
//
// One input byte is taken per cycle while the four-entry bundle queue has room.
// The back end sends one token byte per cycle while a bundle waits and rsp_tready
// is high, so a byte that causes k token bytes occupies the output for k transfers;
// the output port sets the sustained rate. The first token byte of an input byte is
// registered in the queue and then in the output register before rsp_tvalid rises.
// Reset is synchronous and clears the scanner state, queue and configuration.
// Output stalls fill the queue and then drop req_tready; input bubbles only empty it.
module comment_skipping_tokenizer_unit import cst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [SET_WIDTH-1:0] csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // text_byte
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // token_byte
   output logic                 rsp_tlast,
   output logic                 rsp_tuser    // run_last
);

   logic       push, pop, full, empty;
   bundle_type push_data, head;

   cst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (full),
      .push_valid (push),
      .push_data  (push_data)
   );

   cst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   cst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
